// ===== sv/bile_pkg.sv =====
// ----------------------------------------------------------------------------
// bile_pkg
// Shared types and constants for the bounded indexed list engine: operation
// codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package bile_pkg;

  localparam int MODE_W = 3;
  localparam int POS_W  = 6;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;

  // capacity register reset value
  localparam logic [CNT_W-1:0] MAX_SIZE_RST = 7'd64;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch_op;
    logic wr_append;
    logic wr_update;
    logic rd_pos;
    logic shift_start;
    logic shift_rd;
    logic shift_wr;
    logic dec_count;
    logic clear_count;
    logic set_ok;
    logic load_result;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              append_ok;
    logic              in_range;
    logic              del_shift;
    logic              shift_more;
    logic              out_busy;
  } stat_t;

endpackage

// ===== sv/bounded_indexed_list_engine_unit.sv =====
// Each accepted input beat passes through the EXEC and DONE states; DONE loads the
// result register once no earlier result is pending. A delete adds a SHIFT_RD and
// SHIFT_WR pass for every entry behind the deleted position, moving one entry per
// pass through the entry memory. A new input beat is taken only back in IDLE.
// Reset clears the list to empty, sets max_size to 64 and drops out_valid;
// no clearing pass is needed, so the block is ready right after reset.
// ----------------------------------------------------------------------------
// bounded_indexed_list_engine_unit
// Ordered list of signed 32-bit values with append, read, update, delete and
// clear operations, one result beat per input beat.
// ----------------------------------------------------------------------------
module bounded_indexed_list_engine_unit #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bile_pkg::MODE_W-1:0]         mode,
  input  logic [bile_pkg::POS_W-1:0]          position,
  input  logic signed [bile_pkg::DATA_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                ok,
  output logic signed [bile_pkg::DATA_W-1:0]  read_value,
  output logic [bile_pkg::CNT_W-1:0]          count,
  output logic                                is_empty,
  output logic                                is_full,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bile_pkg::CNT_W-1:0]          cfg_data
);

  bile_pkg::cmd_t  cmd;
  bile_pkg::stat_t stat;

  // capacity writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer
  bile_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // list storage and result register
  bile_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .mode       (mode),
    .position   (position),
    .value      (value),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .read_value (read_value),
    .count      (count),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

endmodule

// ===== sv/bile_ctrl.sv =====
// ----------------------------------------------------------------------------
// bile_ctrl
// Operation sequencer: takes one beat, decodes it against the datapath
// status and steps the datapath through the access and shift sequence.
// ----------------------------------------------------------------------------
module bile_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bile_pkg::stat_t stat,
  output bile_pkg::cmd_t  cmd
);

  bile_pkg::state_t state;
  bile_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bile_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      bile_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_op = 1'b1;
          state_next   = bile_pkg::ST_EXEC;
        end
      end
      bile_pkg::ST_EXEC: begin
        state_next = bile_pkg::ST_DONE;
        case (stat.mode)
          bile_pkg::MODE_APPEND: begin
            if (stat.append_ok) begin
              cmd.wr_append = 1'b1;
              cmd.set_ok    = 1'b1;
            end
          end
          bile_pkg::MODE_READ: begin
            if (stat.in_range) begin
              cmd.rd_pos = 1'b1;
              cmd.set_ok = 1'b1;
            end
          end
          bile_pkg::MODE_UPDATE: begin
            if (stat.in_range) begin
              cmd.wr_update = 1'b1;
              cmd.set_ok    = 1'b1;
            end
          end
          bile_pkg::MODE_DELETE: begin
            if (stat.in_range) begin
              cmd.set_ok = 1'b1;
              if (stat.del_shift) begin
                cmd.shift_start = 1'b1;
                state_next      = bile_pkg::ST_SHIFT_RD;
              end else begin
                cmd.dec_count = 1'b1;
              end
            end
          end
          bile_pkg::MODE_CLEAR: begin
            cmd.clear_count = 1'b1;
            cmd.set_ok      = 1'b1;
          end
          default: begin
          end
        endcase
      end
      bile_pkg::ST_SHIFT_RD: begin
        cmd.shift_rd = 1'b1;
        state_next   = bile_pkg::ST_SHIFT_WR;
      end
      bile_pkg::ST_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        if (stat.shift_more) begin
          state_next = bile_pkg::ST_SHIFT_RD;
        end else begin
          cmd.dec_count = 1'b1;
          state_next    = bile_pkg::ST_DONE;
        end
      end
      bile_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_result = 1'b1;
          state_next      = bile_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bile_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/bile_dp.sv =====
// ----------------------------------------------------------------------------
// bile_dp
// List datapath: entry memory, entry count, capacity register, shift index
// and the result register that drives the output channel.
// ----------------------------------------------------------------------------
module bile_dp #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bile_pkg::cmd_t                      cmd,
  output bile_pkg::stat_t                     stat,
  input  logic [bile_pkg::MODE_W-1:0]         mode,
  input  logic [bile_pkg::POS_W-1:0]          position,
  input  logic signed [bile_pkg::DATA_W-1:0]  value,
  input  logic                                cfg_valid,
  input  logic [bile_pkg::CNT_W-1:0]          cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                ok,
  output logic signed [bile_pkg::DATA_W-1:0]  read_value,
  output logic [bile_pkg::CNT_W-1:0]          count,
  output logic                                is_empty,
  output logic                                is_full
);

  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW      = ((AW > bile_pkg::CNT_W) ? AW : bile_pkg::CNT_W) + 1;
  localparam int CAP_MAX = (DEPTH > 127) ? 127 : DEPTH;
  localparam logic [bile_pkg::CNT_W-1:0] CAP_LIM = bile_pkg::CNT_W'(CAP_MAX);

  logic [bile_pkg::DATA_W-1:0] mem [DEPTH];

  logic [bile_pkg::MODE_W-1:0] op_mode;
  logic [bile_pkg::POS_W-1:0]  op_pos;
  logic [bile_pkg::DATA_W-1:0] op_value;
  logic                        op_ok;
  logic [bile_pkg::CNT_W-1:0]  entry_count;
  logic [bile_pkg::CNT_W-1:0]  max_size;
  logic [AW-1:0]               idx;
  logic [bile_pkg::DATA_W-1:0] rdata;

  logic [bile_pkg::CNT_W-1:0]  cap;
  logic                        wr_en;
  logic [AW-1:0]               waddr;
  logic [bile_pkg::DATA_W-1:0] wdata;
  logic                        rd_en;
  logic [AW-1:0]               raddr;

  // effective capacity
  assign cap = (max_size > CAP_LIM) ? CAP_LIM : max_size;

  // status toward the controller
  always_comb begin
    stat.mode       = op_mode;
    stat.append_ok  = entry_count < cap;
    stat.in_range   = {1'b0, op_pos} < entry_count;
    stat.del_shift  = (XW'(op_pos) + XW'(1)) < XW'(entry_count);
    stat.shift_more = (XW'(idx) + XW'(2)) < XW'(entry_count);
    stat.out_busy   = out_valid && !out_ready;
  end

  // memory port selection
  always_comb begin
    wr_en = cmd.wr_append || cmd.wr_update || cmd.shift_wr;
    if (cmd.wr_append) begin
      waddr = AW'(entry_count);
    end else if (cmd.wr_update) begin
      waddr = AW'(op_pos);
    end else begin
      waddr = idx;
    end
    wdata = cmd.shift_wr ? rdata : op_value;
    rd_en = cmd.rd_pos || cmd.shift_rd;
    raddr = cmd.rd_pos ? AW'(op_pos) : AW'(idx + 1'b1);
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // operation latch and shift index
  always_ff @(posedge clk) begin
    if (cmd.latch_op) begin
      op_mode  <= mode;
      op_pos   <= position;
      op_value <= value;
    end
    if (cmd.shift_start) begin
      idx <= AW'(op_pos);
    end else if (cmd.shift_wr) begin
      idx <= idx + 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      max_size    <= bile_pkg::MAX_SIZE_RST;
      op_ok       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_size <= cfg_data;
      end
      if (cmd.latch_op) begin
        op_ok <= 1'b0;
      end else if (cmd.set_ok) begin
        op_ok <= 1'b1;
      end
      if (cmd.clear_count) begin
        entry_count <= '0;
      end else if (cmd.wr_append) begin
        entry_count <= entry_count + 1'b1;
      end else if (cmd.dec_count) begin
        entry_count <= entry_count - 1'b1;
      end
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      ok         <= op_ok;
      read_value <= (op_ok && op_mode == bile_pkg::MODE_READ) ? $signed(rdata) : '0;
      count      <= entry_count;
      is_empty   <= entry_count == '0;
      is_full    <= entry_count >= cap;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(entry_count) <= DEPTH)
    else $error("entry count exceeds depth");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> !(out_valid && !out_ready))
    else $error("result loaded over a pending beat");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.wr_append, cmd.wr_update, cmd.shift_wr}))
    else $error("conflicting memory writes");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_wr |-> (XW'(idx) + XW'(1)) < XW'(entry_count))
    else $error("shift beyond the tail");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> read_value == '0)
    else $error("read value nonzero on a refused operation");
`endif

endmodule

// ===== tb/sv/tb_bounded_indexed_list_engine_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_indexed_list_engine_unit
// Self-checking bench for the bounded indexed list engine. A scoreboard keeps
// its own copy of the list and the capacity, predicts one result beat per
// accepted operation and compares every result field in order. A directed
// opening covers empty-list refusals, extreme values, a delete of the only
// entry and the unused modes. Random phases follow, each under a max_size
// written before it (zero, one, 127 and values below the current count among
// them), with fill, churn and drain mixes and random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_bounded_indexed_list_engine_unit;

  localparam int LIST_DEPTH = 64;
  localparam int PHASE_ITEMS = 128;
  localparam int NUM_PHASES = 12;
  localparam int IDLE_PAD = 8;
  localparam int CYCLE_LIMIT = 1500000;

  // mixes of operations for the random phases
  localparam int STYLE_FILL = 0;
  localparam int STYLE_CHURN = 1;
  localparam int STYLE_DRAIN = 2;

  // mode codes with no operation behind them
  localparam logic [bile_pkg::MODE_W-1:0] MODE_UNUSED_LO  = 3'd5;
  localparam logic [bile_pkg::MODE_W-1:0] MODE_UNUSED_MID = 3'd6;
  localparam logic [bile_pkg::MODE_W-1:0] MODE_UNUSED_HI  = 3'd7;

  typedef struct packed {
    logic                        ok;
    logic [bile_pkg::DATA_W-1:0] rd;
    logic [bile_pkg::CNT_W-1:0]  cnt;
    logic                        empty;
    logic                        full;
  } list_result_t;

  // shadow list and queue of result beats still owed by the block
  class list_scoreboard;
    logic [bile_pkg::DATA_W-1:0] entries [LIST_DEPTH];
    int unsigned entry_count;
    int unsigned max_size;
    list_result_t expected_q[$];
    int errors;

    function new();
      entry_count = 0;
      max_size = bile_pkg::MAX_SIZE_RST;
      errors = 0;
    endfunction

    function void note_max_size(logic [bile_pkg::CNT_W-1:0] v);
      max_size = v;
    endfunction

    // apply one accepted operation to the shadow list
    function void note_op(logic [bile_pkg::MODE_W-1:0] op, logic [bile_pkg::POS_W-1:0] pos,
                          logic [bile_pkg::DATA_W-1:0] val);
      list_result_t res;
      int unsigned cap;
      bit in_range;
      int unsigned k;
      cap = (max_size > LIST_DEPTH) ? LIST_DEPTH : max_size;
      in_range = (pos < entry_count);
      res = '0;
      case (op)
        bile_pkg::MODE_APPEND: begin
          if (entry_count < cap) begin
            entries[entry_count] = val;
            entry_count++;
            res.ok = 1'b1;
          end
        end
        bile_pkg::MODE_READ: begin
          if (in_range) begin
            res.rd = entries[pos];
            res.ok = 1'b1;
          end
        end
        bile_pkg::MODE_UPDATE: begin
          if (in_range) begin
            entries[pos] = val;
            res.ok = 1'b1;
          end
        end
        bile_pkg::MODE_DELETE: begin
          if (in_range) begin
            for (k = pos; k + 1 < entry_count; k++) entries[k] = entries[k + 1];
            entry_count--;
            res.ok = 1'b1;
          end
        end
        bile_pkg::MODE_CLEAR: begin
          entry_count = 0;
          res.ok = 1'b1;
        end
        default: ;
      endcase
      res.cnt = entry_count[bile_pkg::CNT_W-1:0];
      res.empty = (entry_count == 0);
      res.full = (entry_count >= cap);
      expected_q.push_back(res);
    endfunction

    function void check_result(logic o, logic [bile_pkg::DATA_W-1:0] rd,
                               logic [bile_pkg::CNT_W-1:0] cnt, logic e, logic f);
      list_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result beat: ok %b read_value %h count %0d",
                 $time, o, rd, cnt);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (o !== exp_res.ok) begin
        $display("%0t ok mismatch: expected %b, actual %b", $time, exp_res.ok, o);
        errors++;
      end
      if (rd !== exp_res.rd) begin
        $display("%0t read_value mismatch: expected %h, actual %h", $time, exp_res.rd, rd);
        errors++;
      end
      if (cnt !== exp_res.cnt) begin
        $display("%0t count mismatch: expected %0d, actual %0d", $time, exp_res.cnt, cnt);
        errors++;
      end
      if (e !== exp_res.empty) begin
        $display("%0t is_empty mismatch: expected %b, actual %b", $time, exp_res.empty, e);
        errors++;
      end
      if (f !== exp_res.full) begin
        $display("%0t is_full mismatch: expected %b, actual %b", $time, exp_res.full, f);
        errors++;
      end
    endfunction
  endclass

  logic                               clk;
  logic                               rst;
  logic                               in_valid;
  logic                               in_ready;
  logic [bile_pkg::MODE_W-1:0]        mode;
  logic [bile_pkg::POS_W-1:0]         position;
  logic signed [bile_pkg::DATA_W-1:0] value;
  logic                               out_valid;
  logic                               out_ready;
  logic                               ok;
  logic signed [bile_pkg::DATA_W-1:0] read_value;
  logic [bile_pkg::CNT_W-1:0]         count;
  logic                               is_empty;
  logic                               is_full;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [bile_pkg::CNT_W-1:0]         cfg_data;

  list_scoreboard list_sb;
  bit calm;
  int unsigned stall_left;
  int unsigned cycle_count;

  bounded_indexed_list_engine_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .position   (position),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .read_value (read_value),
    .count      (count),
    .is_empty   (is_empty),
    .is_full    (is_full),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // idle length: mostly short, now and then long
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned send_gap();
    if (calm || $urandom_range(0, 99) < 55) return 0;
    return gap_len();
  endfunction

  function automatic logic [bile_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [bile_pkg::MODE_W-1:0] pick_mode(int style);
    int unsigned r;
    int unsigned app_pct;
    int unsigned del_pct;
    int unsigned clr_pct;
    r = $urandom_range(0, 99);
    app_pct = (style == STYLE_FILL) ? 55 : (style == STYLE_CHURN) ? 30 : 20;
    del_pct = (style == STYLE_DRAIN) ? 42 : (style == STYLE_CHURN) ? 25 : 12;
    clr_pct = (style == STYLE_FILL) ? 0 : 2;
    if (r < app_pct) return bile_pkg::MODE_APPEND;
    if (r < app_pct + del_pct) return bile_pkg::MODE_DELETE;
    if (r < 96 - clr_pct) return (r % 3 == 0) ? bile_pkg::MODE_UPDATE : bile_pkg::MODE_READ;
    if (r < 96) return bile_pkg::MODE_CLEAR;
    r = $urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO);
    return r[bile_pkg::MODE_W-1:0];
  endfunction

  // drive one operation beat and hold it until accepted
  task automatic send_op(input logic [bile_pkg::MODE_W-1:0] op,
                         input logic [bile_pkg::POS_W-1:0] pos,
                         input logic [bile_pkg::DATA_W-1:0] val);
    int unsigned gap;
    gap = send_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= op;
    position <= pos;
    value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    list_sb.note_op(op, pos, val);
  endtask

  // drop valid and wait until every owed result beat has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (list_sb.expected_q.size() != 0) @(posedge clk);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  task automatic write_max_size(input logic [bile_pkg::CNT_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    list_sb.note_max_size(v);
    cfg_valid <= 1'b0;
  endtask

  // result side: random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      out_ready <= 1'b0;
      stall_left <= gap_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && out_ready)
      list_sb.check_result(ok, read_value, count, is_empty, is_full);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_bounded_indexed_list_engine_unit: done, errors");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [bile_pkg::CNT_W-1:0] phase_size [NUM_PHASES];
    int phase_style [NUM_PHASES];
    logic [bile_pkg::MODE_W-1:0] op;
    logic [bile_pkg::POS_W-1:0] pos;
    int unsigned pick;
    int p;
    int n;

    phase_size = '{7'd64, 7'd127, 7'd8, 7'd0, 7'd1, 7'd64,
                   7'd2, 7'd100, 7'd33, 7'd17, 7'd64, 7'd45};
    phase_style = '{STYLE_FILL, STYLE_FILL, STYLE_CHURN, STYLE_CHURN, STYLE_FILL,
                    STYLE_DRAIN, STYLE_CHURN, STYLE_FILL, STYLE_DRAIN, STYLE_CHURN,
                    STYLE_FILL, STYLE_DRAIN};

    list_sb = new();
    calm = 1'b0;
    cycle_count = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    mode <= bile_pkg::MODE_APPEND;
    position <= '0;
    value <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list refusals and clear on empty
    send_op(bile_pkg::MODE_READ, 6'd0, 32'h0);
    send_op(bile_pkg::MODE_UPDATE, 6'd0, 32'h5555_aaaa);
    send_op(bile_pkg::MODE_DELETE, 6'd0, 32'h0);
    send_op(bile_pkg::MODE_CLEAR, 6'd0, 32'h0);
    // delete of the only entry
    send_op(bile_pkg::MODE_APPEND, 6'd0, 32'h7fff_ffff);
    send_op(bile_pkg::MODE_DELETE, 6'd0, 32'h0);
    // extremes of value and position
    send_op(bile_pkg::MODE_APPEND, 6'd63, 32'h8000_0000);
    send_op(bile_pkg::MODE_APPEND, 6'd0, 32'hffff_ffff);
    send_op(bile_pkg::MODE_APPEND, 6'd0, 32'h0000_0000);
    send_op(bile_pkg::MODE_READ, 6'd0, 32'h0);
    send_op(bile_pkg::MODE_READ, 6'd2, 32'h0);
    send_op(bile_pkg::MODE_READ, 6'd3, 32'h0);
    send_op(bile_pkg::MODE_READ, 6'd63, 32'hffff_ffff);
    send_op(bile_pkg::MODE_UPDATE, 6'd1, 32'h1234_5678);
    send_op(bile_pkg::MODE_UPDATE, 6'd63, 32'h0);
    // delete in the middle closes the gap
    send_op(bile_pkg::MODE_DELETE, 6'd1, 32'h0);
    send_op(bile_pkg::MODE_READ, 6'd1, 32'h0);
    send_op(bile_pkg::MODE_DELETE, 6'd63, 32'h0);
    // unused modes
    send_op(MODE_UNUSED_LO, 6'd0, 32'h0);
    send_op(MODE_UNUSED_MID, 6'd21, 32'hdead_beef);
    send_op(MODE_UNUSED_HI, 6'd42, 32'hffff_ffff);
    send_op(bile_pkg::MODE_CLEAR, 6'd63, 32'hffff_ffff);

    // random phases, each under its own capacity
    for (p = 0; p < NUM_PHASES; p++) begin
      write_max_size(phase_size[p]);
      calm = (p % 4 == 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        op = pick_mode(phase_style[p]);
        if (list_sb.entry_count > 0 && $urandom_range(0, 9) < 7)
          pick = $urandom_range(0, list_sb.entry_count - 1);
        else
          pick = $urandom_range(0, LIST_DEPTH - 1);
        pos = pick[bile_pkg::POS_W-1:0];
        send_op(op, pos, pick_value());
      end
    end

    calm = 1'b0;
    settle();
    if (list_sb.errors == 0) begin
      $display("tb_bounded_indexed_list_engine_unit: done, clean");
    end else begin
      $display("tb_bounded_indexed_list_engine_unit: done, errors");
    end
    $finish;
  end

endmodule
